// ----- sv/ladg_pkg.sv -----
// Package for the Log-ACD type 2 duration generator.
// Holds item and record types, register indexes and the exp root table.
// No dependencies.
package ladg_pkg;

	localparam int DATA_W              = 32;
	localparam int CFG_IDX_W           = 3;
	localparam int LAG_W               = 2;
	localparam int BURN_W              = 20;
	localparam int EXP_BITS            = 16;
	localparam int DEF_MAX_INNOV_LAGS  = 2;
	localparam int DEF_MAX_MEAN_LAGS   = 2;
	localparam int DEF_FRAC_BITS       = 16;
	localparam logic [30:0] LOG2E_Q30  = 31'd1549082005;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_OMEGA      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_ONE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_TWO  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BETA_ONE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BETA_TWO   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INNOV_LAGS = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MEAN_LAGS  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_BURN_COUNT = 3'd7;

	typedef struct packed {
		logic               action;
		logic [31:0]        innovation;
		logic signed [31:0] seed_log_mean;
		logic [31:0]        seed_duration;
		logic               final_item;
	} in_item_t;

	typedef struct packed {
		logic [31:0] duration;
		logic        saturated;
		logic        final_result;
	} out_item_t;

	// One classified item handed from the front to the back.
	typedef struct packed {
		logic               simulate;
		logic signed [31:0] log_mean;
		logic [31:0]        innovation;
		logic [31:0]        seed_duration;
		logic               final_item;
	} rec_t;

	// Floor square root, evaluated at elaboration only.
	function automatic logic [63:0] isqrt64(input logic [63:0] n);
		logic [63:0] res;
		logic [63:0] cand;
		res = '0;
		for (int b = 31; b >= 0; b--) begin
			cand = res | (64'd1 << b);
			if (cand * cand <= n) res = cand;
		end
		return res;
	endfunction

	// Chain of square roots from 2.0 in Q30: entry i is 2^(2^-(i+1)).
	function automatic logic [EXP_BITS-1:0][31:0] build_roots();
		logic [EXP_BITS-1:0][31:0] tab;
		logic [63:0] r;
		r = isqrt64(64'd1 << 61);
		tab[0] = r[31:0];
		for (int i = 1; i < EXP_BITS; i++) begin
			r = isqrt64(r << 30);
			tab[i] = r[31:0];
		end
		return tab;
	endfunction

	localparam logic [EXP_BITS-1:0][31:0] ROOT_TABLE = build_roots();

endpackage

// ----- sv/ladg_queue.sv -----
// Two-entry queue of classified records between front and back.
// Depends on ladg_pkg.
module ladg_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ladg_pkg::rec_t push_data,
	output logic          has_room,
	output logic          pop_valid,
	input  logic          pop,
	output ladg_pkg::rec_t pop_data
);
	import ladg_pkg::*;

	rec_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign has_room  = (count_q != 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_data  = slot_q[rd_ptr_q];

	// Storage is written without reset.
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_data;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

// ----- sv/ladg_front.sv -----
// Front end: configuration registers, history, burn-in and the log-mean recursion.
// Accepts items, forms the log-mean with one multiply-accumulate per cycle.
// Depends on ladg_pkg.
module ladg_front #(
	parameter int MAX_INNOVATION_LAGS = ladg_pkg::DEF_MAX_INNOV_LAGS,
	parameter int MAX_MEAN_LAGS       = ladg_pkg::DEF_MAX_MEAN_LAGS,
	parameter int FRAC_BITS           = ladg_pkg::DEF_FRAC_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  ladg_pkg::in_item_t               in_data,
	input  logic                             cfg_we,
	input  logic [ladg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ladg_pkg::DATA_W-1:0]      cfg_data,
	input  logic                             q_room,
	output logic                             q_push,
	output ladg_pkg::rec_t                   q_data
);
	import ladg_pkg::*;

	localparam int ACC_W = 68 - FRAC_BITS;
	localparam logic [LAG_W-1:0] MAX_I =
		(MAX_INNOVATION_LAGS > 2) ? LAG_W'(2) : LAG_W'(MAX_INNOVATION_LAGS);
	localparam logic [LAG_W-1:0] MAX_M =
		(MAX_MEAN_LAGS > 2) ? LAG_W'(2) : LAG_W'(MAX_MEAN_LAGS);

	typedef enum logic [1:0] {ST_IDLE, ST_MAC, ST_FIN} state_t;

	state_t             state_q;
	logic signed [31:0] omega_q, alpha_one_q, alpha_two_q, beta_one_q, beta_two_q;
	logic [LAG_W-1:0]   innov_lags_q, mean_lags_q;
	logic [BURN_W-1:0]  burn_count_q, burn_rem_q;
	logic [31:0]        ihist_q [2];
	logic signed [31:0] lhist_q [2];
	in_item_t           cur_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [1:0]         term_q;

	logic [LAG_W-1:0]   n_innov, n_mean;
	logic               term_on;
	logic signed [31:0] weight;
	logic signed [32:0] operand;
	logic signed [64:0] prod;
	logic signed [64:0] prod_sh;
	logic signed [31:0] lm_clip;
	logic               accept;
	logic               ret_valid;
	logic [31:0]        ret_e;
	logic signed [31:0] ret_lm;
	logic               ret_final;

	assign in_ready = (state_q == ST_IDLE) && q_room;
	assign accept   = in_valid && in_ready;

	// Lag counts in use: least of register, parameter and two.
	assign n_innov = (innov_lags_q > MAX_I) ? MAX_I : innov_lags_q;
	assign n_mean  = (mean_lags_q > MAX_M) ? MAX_M : mean_lags_q;

	// Select the weight and lagged value of the current term.
	always_comb begin
		case (term_q)
			2'd0: begin
				weight  = alpha_one_q;
				operand = $signed({1'b0, ihist_q[0]});
				term_on = (n_innov > LAG_W'(0));
			end
			2'd1: begin
				weight  = alpha_two_q;
				operand = $signed({1'b0, ihist_q[1]});
				term_on = (n_innov > LAG_W'(1));
			end
			2'd2: begin
				weight  = beta_one_q;
				operand = {lhist_q[0][31], lhist_q[0]};
				term_on = (n_mean > LAG_W'(0));
			end
			default: begin
				weight  = beta_two_q;
				operand = {lhist_q[1][31], lhist_q[1]};
				term_on = (n_mean > LAG_W'(1));
			end
		endcase
	end

	// Exact product, floored back to the fixed-point scale.
	assign prod    = weight * operand;
	assign prod_sh = prod >>> FRAC_BITS;

	// Clip the accumulated sum to the signed 32-bit range.
	always_comb begin
		if (acc_q > ACC_W'(signed'(33'sh0_7FFF_FFFF)))
			lm_clip = 32'sh7FFF_FFFF;
		else if (acc_q < ACC_W'(-(signed'(33'sh0_8000_0000))))
			lm_clip = 32'sh8000_0000;
		else
			lm_clip = acc_q[31:0];
	end

	// An item retires either directly as a seed or at the end of its recursion.
	always_comb begin
		ret_valid = 1'b0;
		ret_e     = cur_q.innovation;
		ret_lm    = lm_clip;
		ret_final = cur_q.final_item;
		q_data.simulate = 1'b1;
		if (state_q == ST_IDLE) begin
			ret_valid       = accept && !in_data.action;
			ret_e           = in_data.innovation;
			ret_lm          = in_data.seed_log_mean;
			ret_final       = in_data.final_item;
			q_data.simulate = 1'b0;
		end else if (state_q == ST_FIN) begin
			ret_valid = 1'b1;
		end
		q_data.log_mean      = ret_lm;
		q_data.innovation    = ret_e;
		q_data.seed_duration = in_data.seed_duration;
		q_data.final_item    = ret_final;
		q_push               = ret_valid && (burn_rem_q == '0);
	end

	// Sequencer, registers and history.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			omega_q      <= '0;
			alpha_one_q  <= '0;
			alpha_two_q  <= '0;
			beta_one_q   <= '0;
			beta_two_q   <= '0;
			innov_lags_q <= LAG_W'(1);
			mean_lags_q  <= LAG_W'(1);
			burn_count_q <= '0;
			burn_rem_q   <= '0;
			ihist_q[0]   <= '0;
			ihist_q[1]   <= '0;
			lhist_q[0]   <= '0;
			lhist_q[1]   <= '0;
			term_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && in_data.action) begin
						term_q  <= '0;
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					term_q <= term_q + 2'd1;
					if (term_q == 2'd3) state_q <= ST_FIN;
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// Retirement updates history, burn-in and end of run.
			if (ret_valid) begin
				if (ret_final) begin
					ihist_q[0] <= '0;
					ihist_q[1] <= '0;
					lhist_q[0] <= '0;
					lhist_q[1] <= '0;
					burn_rem_q <= burn_count_q;
				end else begin
					ihist_q[1] <= ihist_q[0];
					ihist_q[0] <= ret_e;
					lhist_q[1] <= lhist_q[0];
					lhist_q[0] <= ret_lm;
					if (burn_rem_q != '0) burn_rem_q <= burn_rem_q - BURN_W'(1);
				end
			end

			// Configuration writes must arrive only while idle; the block itself does not enforce this.
			if (cfg_we) begin
				case (cfg_index)
					REG_OMEGA:      omega_q      <= cfg_data;
					REG_ALPHA_ONE:  alpha_one_q  <= cfg_data;
					REG_ALPHA_TWO:  alpha_two_q  <= cfg_data;
					REG_BETA_ONE:   beta_one_q   <= cfg_data;
					REG_BETA_TWO:   beta_two_q   <= cfg_data;
					REG_INNOV_LAGS: innov_lags_q <= cfg_data[LAG_W-1:0];
					REG_MEAN_LAGS:  mean_lags_q  <= cfg_data[LAG_W-1:0];
					REG_BURN_COUNT: begin
						burn_count_q <= cfg_data[BURN_W-1:0];
						burn_rem_q   <= cfg_data[BURN_W-1:0];
					end
					default: ;
				endcase
			end
		end
	end

	// Item payload and accumulator need no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q <= in_data;
			acc_q <= ACC_W'(omega_q);
		end else if (state_q == ST_MAC && term_on) begin
			acc_q <= acc_q + prod_sh[ACC_W-1:0];
		end
	end
endmodule

// ----- sv/ladg_back.sv -----
// Back end: exp of the log-mean times the innovation, with saturation.
// One multiply per cycle over the root table, then a shift; holds the output register.
// Depends on ladg_pkg.
module ladg_back #(
	parameter int FRAC_BITS = ladg_pkg::DEF_FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 q_pop,
	input  ladg_pkg::rec_t       q_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ladg_pkg::out_item_t  out_data
);
	import ladg_pkg::*;

	localparam int FB  = FRAC_BITS + 30;
	localparam int KW  = 66 - FB;
	localparam int RIW = $clog2(EXP_BITS);

	typedef enum logic [2:0] {ST_IDLE, ST_TMUL, ST_ROOT, ST_PROD, ST_SHIFT} state_t;

	state_t             state_q;
	rec_t               rec_q;
	logic signed [KW-1:0] s_q;
	logic [EXP_BITS-1:0] frac_q;
	logic [RIW-1:0]     idx_q;
	logic [31:0]        m_q;
	logic [63:0]        p_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic               slot_free;
	logic signed [63:0] t;
	logic [63:0]        m_prod;
	logic [63:0]        p_prod;
	logic [KW-1:0]      neg_s;
	logic [95:0]        wide;
	logic [63:0]        r;
	logic [31:0]        dur;
	logic               sat;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign q_pop     = (state_q == ST_IDLE) && q_valid && (q_data.simulate || slot_free);

	// Log-mean scaled to base two.
	assign t = 64'(rec_q.log_mean) * $signed({33'd0, LOG2E_Q30});

	// Root factor multiply and final product.
	assign m_prod = 64'(m_q) * 64'(ROOT_TABLE[idx_q]);
	assign p_prod = 64'(m_q) * 64'(rec_q.innovation);

	// Scale by 2^(k-30) and clip.
	always_comb begin
		neg_s = -s_q;
		wide  = 96'(p_q) << s_q[4:0];
		r     = p_q >> neg_s[5:0];
		dur   = '0;
		sat   = 1'b0;
		if (p_q == '0) begin
			dur = '0;
		end else if (!s_q[KW-1]) begin
			if (s_q >= KW'(32) || wide[95:32] != '0) begin
				sat = 1'b1;
				dur = '1;
			end else begin
				dur = wide[31:0];
			end
		end else if (neg_s >= KW'(64)) begin
			dur = '0;
		end else if (r[63:32] != '0) begin
			sat = 1'b1;
			dur = '1;
		end else begin
			dur = r[31:0];
		end
	end

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						if (q_data.simulate) begin
							state_q <= ST_TMUL;
						end else begin
							out_valid_q <= 1'b1;
						end
					end
				end
				ST_TMUL:  state_q <= ST_ROOT;
				ST_ROOT: begin
					if (idx_q == RIW'(EXP_BITS - 1)) state_q <= ST_PROD;
				end
				ST_PROD:  state_q <= ST_SHIFT;
				ST_SHIFT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (q_pop) begin
					rec_q <= q_data;
					if (!q_data.simulate) begin
						out_q.duration     <= q_data.seed_duration;
						out_q.saturated    <= 1'b0;
						out_q.final_result <= q_data.final_item;
					end
				end
			end
			ST_TMUL: begin
				s_q    <= KW'(t >>> FB) - KW'(30);
				frac_q <= t[FB-1 -: EXP_BITS];
				m_q    <= 32'd1 << 30;
				idx_q  <= '0;
			end
			ST_ROOT: begin
				if (frac_q[EXP_BITS-1]) m_q <= m_prod[61:30];
				frac_q <= frac_q << 1;
				idx_q  <= idx_q + RIW'(1);
			end
			ST_PROD: begin
				p_q <= p_prod;
			end
			ST_SHIFT: begin
				if (slot_free) begin
					out_q.duration     <= dur;
					out_q.saturated    <= sat;
					out_q.final_result <= rec_q.final_item;
				end
			end
			default: ;
		endcase
	end
endmodule

// ----- sv/log_acd_duration_generator_core.sv -----
// Log-ACD type 2 duration generator, Q16.16 fixed point, front and back joined by a queue.
// Front: a seed item retires in the cycle it is accepted; a simulate item holds the front for four
// serial multiply-accumulate steps, then retires. Back: a simulate record goes through the base-two
// scaling, 16 root multiply steps, the final product and the shift; the back takes no new record
// until the result is in the output register, which a held output can stall.
// Reset clears registers, history, queue and output valid; no clearing pass is needed.
module log_acd_duration_generator_core #(
	parameter int MAX_INNOVATION_LAGS = ladg_pkg::DEF_MAX_INNOV_LAGS,
	parameter int MAX_MEAN_LAGS       = ladg_pkg::DEF_MAX_MEAN_LAGS,
	parameter int FRAC_BITS           = ladg_pkg::DEF_FRAC_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  ladg_pkg::in_item_t             in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output ladg_pkg::out_item_t            out_data,
	input  logic                           cfg_we,
	input  logic [ladg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ladg_pkg::DATA_W-1:0]    cfg_data
);
	import ladg_pkg::*;

	logic q_room;
	logic q_push;
	logic q_valid;
	logic q_pop;
	rec_t q_in;
	rec_t q_out;

	// Front end: classification and recursion.
	ladg_front #(
		.MAX_INNOVATION_LAGS(MAX_INNOVATION_LAGS),
		.MAX_MEAN_LAGS(MAX_MEAN_LAGS),
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.q_room(q_room), .q_push(q_push), .q_data(q_in)
	);

	// Queue between the two halves.
	ladg_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(q_push), .push_data(q_in), .has_room(q_room),
		.pop_valid(q_valid), .pop(q_pop), .pop_data(q_out)
	);

	// Back end: exp and scaling.
	ladg_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_pop(q_pop), .q_data(q_out),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);
endmodule
